@@ rtl/ppe_pkg.sv @@
// Shared constants of the polynomial product engine: field widths,
// item kinds, reply kinds and error codes. No dependencies.
`timescale 1ns / 1ps

package ppe_pkg;

  localparam int MAX_TERMS_DEF = 1024;

  localparam int KIND_W  = 2;
  localparam int COEFF_W = 16;
  localparam int INDEX_W = 11;
  localparam int VALUE_W = 42;
  localparam int TERMS_W = 11;
  localparam int ERR_W   = 2;
  localparam int MUL_W   = 2 * COEFF_W;

  localparam logic [KIND_W-1:0] KIND_LOAD_A = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOAD_B = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;

  localparam logic REPLY_REPORT = 1'b0;
  localparam logic REPLY_READ   = 1'b1;

  localparam logic [ERR_W-1:0] ERR_NONE     = 2'd0;
  localparam logic [ERR_W-1:0] ERR_OVERFLOW = 2'd1;
  localparam logic [ERR_W-1:0] ERR_ABSENT   = 2'd2;

endpackage

@@ rtl/ppe_ram.sv @@
// Generic single-port synchronous RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps

module ppe_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/polynomial_product_engine.sv @@
// Top level of the polynomial product engine; uses ppe_pkg and ppe_ram.
// Holds the load and read control and the multiply-accumulate sequencer.
`timescale 1ns / 1ps

// Coefficient loads are taken one per cycle while the engine is idle, and a
// read request passes through the RD state because the product RAM has a
// registered read. Closing B after a closed A starts the convolution: every
// product coefficient k is summed by one shared 16x16 multiply-accumulate
// unit fed by one read port of each coefficient RAM, in the setup, issue and
// drain states; during the whole product no request is accepted. Requests
// that yield no result are accepted while a result waits on the output;
// others wait for it.
module polynomial_product_engine #(
  parameter int MAX_TERMS = ppe_pkg::MAX_TERMS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [ppe_pkg::KIND_W-1:0]         in_kind,
  input  logic signed [ppe_pkg::COEFF_W-1:0] in_coeff_value,
  input  logic                               in_final_term,
  input  logic [ppe_pkg::INDEX_W-1:0]        in_read_index,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_reply_kind,
  output logic signed [ppe_pkg::VALUE_W-1:0] out_result_value,
  output logic [ppe_pkg::TERMS_W-1:0]        out_product_terms,
  output logic [ppe_pkg::ERR_W-1:0]          out_error_code
);

  import ppe_pkg::*;

  localparam int PROD_DEPTH = 2 * MAX_TERMS - 1;
  localparam int AAW  = $clog2(MAX_TERMS);
  localparam int PAW  = $clog2(PROD_DEPTH);
  localparam int CNTW = $clog2(MAX_TERMS + 1);
  localparam int IXW  = (PAW > INDEX_W) ? PAW : INDEX_W;
  localparam int OTW  = (PAW > TERMS_W) ? PAW : TERMS_W;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_RD    = 3'd1;
  localparam logic [2:0] ST_SETUP = 3'd2;
  localparam logic [2:0] ST_ISSUE = 3'd3;
  localparam logic [2:0] ST_DRAIN = 3'd4;

  logic [2:0]      state_r, state_nxt;
  logic [CNTW-1:0] a_cnt_r, a_cnt_nxt, b_cnt_r, b_cnt_nxt;
  logic            a_closed_r, a_closed_nxt, b_closed_r, b_closed_nxt;
  logic            prod_ok_r, prod_ok_nxt, ovf_r, ovf_nxt;
  logic [PAW-1:0]  terms_r, terms_nxt, k_r, k_nxt;
  logic [AAW-1:0]  i_r, i_nxt, j_r, j_nxt, hi_r, hi_nxt;
  logic            rd_v_r, rd_v_nxt, rd_last_r, rd_last_nxt;
  logic            mul_v_r, mul_v_nxt, mul_last_r, mul_last_nxt;
  logic signed [MUL_W-1:0]   mul_r, mul_nxt;
  logic signed [VALUE_W-1:0] acc_r, acc_nxt, xor_r, xor_nxt;

  logic                      out_valid_r, out_valid_nxt;
  logic                      out_kind_r, out_kind_nxt;
  logic signed [VALUE_W-1:0] out_value_r, out_value_nxt;
  logic [TERMS_W-1:0]        out_terms_r, out_terms_nxt;
  logic [ERR_W-1:0]          out_err_r, out_err_nxt;

  logic                a_we, b_we, p_we;
  logic [AAW-1:0]      a_addr, b_addr;
  logic [PAW-1:0]      p_addr;
  logic [COEFF_W-1:0]  a_q, b_q;
  logic [VALUE_W-1:0]  p_q;
  logic signed [COEFF_W-1:0] a_sq, b_sq;

  logic                in_acc, needs_out;
  logic [CNTW-1:0]     a_base, b_base, b_new;
  logic [IXW-1:0]      idx_ext;
  logic [OTW-1:0]      terms_ext;
  logic [PAW-1:0]      ac_ext, bc_ext, lo, hi, jst;
  logic signed [VALUE_W-1:0] sum;

  // Requests that can yield a result need a free output register.
  assign needs_out = (in_kind == KIND_READ) ||
                     ((in_kind == KIND_LOAD_B) && in_final_term);
  assign in_stall  = (state_r != ST_IDLE) || (out_valid_r && needs_out);
  assign in_acc    = in_valid && !in_stall;

  assign a_base    = a_closed_r ? '0 : a_cnt_r;
  assign b_base    = b_closed_r ? '0 : b_cnt_r;
  assign b_new     = (b_base < CNTW'(MAX_TERMS)) ? b_base + 1'b1 : b_base;
  assign idx_ext   = IXW'(in_read_index);
  assign terms_ext = OTW'(terms_r);

  assign ac_ext = PAW'(a_cnt_r);
  assign bc_ext = PAW'(b_cnt_r);
  // Range of A indices that contribute to coefficient k.
  assign lo  = (k_r >= bc_ext) ? k_r - bc_ext + 1'b1 : '0;
  assign hi  = (k_r < ac_ext) ? k_r : ac_ext - 1'b1;
  assign jst = k_r - lo;

  assign a_sq = a_q;
  assign b_sq = b_q;
  assign sum  = acc_r + VALUE_W'(mul_r);

  assign a_we   = (state_r == ST_IDLE) && in_acc && (in_kind == KIND_LOAD_A) &&
                  (a_base < CNTW'(MAX_TERMS));
  assign b_we   = (state_r == ST_IDLE) && in_acc && (in_kind == KIND_LOAD_B) &&
                  (b_base < CNTW'(MAX_TERMS));
  assign a_addr = (state_r == ST_IDLE) ? a_base[AAW-1:0] : i_r;
  assign b_addr = (state_r == ST_IDLE) ? b_base[AAW-1:0] : j_r;
  assign p_we   = (state_r == ST_DRAIN) && mul_v_r && mul_last_r;
  assign p_addr = p_we ? k_r : idx_ext[PAW-1:0];

  ppe_ram #(.WIDTH(COEFF_W), .DEPTH(MAX_TERMS)) u_a_ram (
    .clk(clk), .we(a_we), .addr(a_addr), .wdata(in_coeff_value), .rdata(a_q)
  );

  ppe_ram #(.WIDTH(COEFF_W), .DEPTH(MAX_TERMS)) u_b_ram (
    .clk(clk), .we(b_we), .addr(b_addr), .wdata(in_coeff_value), .rdata(b_q)
  );

  ppe_ram #(.WIDTH(VALUE_W), .DEPTH(PROD_DEPTH)) u_p_ram (
    .clk(clk), .we(p_we), .addr(p_addr), .wdata(sum), .rdata(p_q)
  );

  always_comb begin
    state_nxt     = state_r;
    a_cnt_nxt     = a_cnt_r;
    b_cnt_nxt     = b_cnt_r;
    a_closed_nxt  = a_closed_r;
    b_closed_nxt  = b_closed_r;
    prod_ok_nxt   = prod_ok_r;
    ovf_nxt       = ovf_r;
    terms_nxt     = terms_r;
    k_nxt         = k_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    hi_nxt        = hi_r;
    acc_nxt       = acc_r;
    xor_nxt       = xor_r;
    rd_v_nxt      = 1'b0;
    rd_last_nxt   = rd_last_r;
    mul_v_nxt     = rd_v_r;
    mul_last_nxt  = rd_last_r;
    mul_nxt       = a_sq * b_sq;
    out_valid_nxt = out_valid_r && out_stall;
    out_kind_nxt  = out_kind_r;
    out_value_nxt = out_value_r;
    out_terms_nxt = out_terms_r;
    out_err_nxt   = out_err_r;

    if (mul_v_r && !mul_last_r) begin
      acc_nxt = sum;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_kind)
            KIND_LOAD_A: begin
              // Loading A after it closed starts a new problem.
              if (a_closed_r) begin
                b_cnt_nxt    = '0;
                b_closed_nxt = 1'b0;
                prod_ok_nxt  = 1'b0;
                ovf_nxt      = 1'b0;
              end
              if (a_base < CNTW'(MAX_TERMS)) begin
                a_cnt_nxt = a_base + 1'b1;
              end else begin
                a_cnt_nxt = a_base;
                ovf_nxt   = 1'b1;
              end
              a_closed_nxt = in_final_term || (a_closed_r ? 1'b0 : a_closed_r);
            end
            KIND_LOAD_B: begin
              if (b_closed_r) begin
                prod_ok_nxt = 1'b0;
              end
              b_cnt_nxt    = b_new;
              b_closed_nxt = in_final_term ? 1'b1 : (b_closed_r ? 1'b0 : b_closed_r);
              if (b_base >= CNTW'(MAX_TERMS)) begin
                ovf_nxt = 1'b1;
              end
              if (in_final_term) begin
                if (!a_closed_r) begin
                  out_valid_nxt = 1'b1;
                  out_kind_nxt  = REPLY_REPORT;
                  out_value_nxt = '0;
                  out_terms_nxt = '0;
                  out_err_nxt   = ERR_ABSENT;
                end else begin
                  terms_nxt = ac_ext + PAW'(b_new) - 1'b1;
                  k_nxt     = '0;
                  xor_nxt   = '0;
                  state_nxt = ST_SETUP;
                end
              end
            end
            KIND_READ: begin
              if (!prod_ok_r) begin
                out_valid_nxt = 1'b1;
                out_kind_nxt  = REPLY_READ;
                out_value_nxt = '0;
                out_terms_nxt = '0;
                out_err_nxt   = ERR_ABSENT;
              end else if (idx_ext >= IXW'(terms_r)) begin
                out_valid_nxt = 1'b1;
                out_kind_nxt  = REPLY_READ;
                out_value_nxt = '0;
                out_terms_nxt = terms_ext[TERMS_W-1:0];
                out_err_nxt   = ERR_ABSENT;
              end else begin
                state_nxt = ST_RD;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_RD: begin
        out_valid_nxt = 1'b1;
        out_kind_nxt  = REPLY_READ;
        out_value_nxt = p_q;
        out_terms_nxt = terms_ext[TERMS_W-1:0];
        out_err_nxt   = ERR_NONE;
        state_nxt     = ST_IDLE;
      end
      ST_SETUP: begin
        i_nxt     = lo[AAW-1:0];
        j_nxt     = jst[AAW-1:0];
        hi_nxt    = hi[AAW-1:0];
        acc_nxt   = '0;
        state_nxt = ST_ISSUE;
      end
      ST_ISSUE: begin
        rd_v_nxt    = 1'b1;
        rd_last_nxt = (i_r == hi_r);
        i_nxt       = i_r + 1'b1;
        j_nxt       = j_r - 1'b1;
        if (i_r == hi_r) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // The last partial product of coefficient k leaves the multiplier.
        if (mul_v_r && mul_last_r) begin
          xor_nxt = xor_r ^ sum;
          if (k_r == terms_r - 1'b1) begin
            prod_ok_nxt   = 1'b1;
            out_valid_nxt = 1'b1;
            out_kind_nxt  = REPLY_REPORT;
            out_value_nxt = xor_r ^ sum;
            out_terms_nxt = terms_ext[TERMS_W-1:0];
            out_err_nxt   = ovf_r ? ERR_OVERFLOW : ERR_NONE;
            state_nxt     = ST_IDLE;
          end else begin
            k_nxt     = k_r + 1'b1;
            state_nxt = ST_SETUP;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      a_cnt_r     <= '0;
      b_cnt_r     <= '0;
      a_closed_r  <= 1'b0;
      b_closed_r  <= 1'b0;
      prod_ok_r   <= 1'b0;
      ovf_r       <= 1'b0;
      rd_v_r      <= 1'b0;
      mul_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      a_cnt_r     <= a_cnt_nxt;
      b_cnt_r     <= b_cnt_nxt;
      a_closed_r  <= a_closed_nxt;
      b_closed_r  <= b_closed_nxt;
      prod_ok_r   <= prod_ok_nxt;
      ovf_r       <= ovf_nxt;
      rd_v_r      <= rd_v_nxt;
      mul_v_r     <= mul_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    terms_r     <= terms_nxt;
    k_r         <= k_nxt;
    i_r         <= i_nxt;
    j_r         <= j_nxt;
    hi_r        <= hi_nxt;
    acc_r       <= acc_nxt;
    xor_r       <= xor_nxt;
    rd_last_r   <= rd_last_nxt;
    mul_last_r  <= mul_last_nxt;
    mul_r       <= mul_nxt;
    out_kind_r  <= out_kind_nxt;
    out_value_r <= out_value_nxt;
    out_terms_r <= out_terms_nxt;
    out_err_r   <= out_err_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_reply_kind    = out_kind_r;
  assign out_result_value  = out_value_r;
  assign out_product_terms = out_terms_r;
  assign out_error_code    = out_err_r;

endmodule
